// ===== rtl/lhc_pkg.sv =====
// shared types and constants for the latency histogram counters
package lhc_pkg;

  // number of bin limit registers on the configuration port
  localparam int unsigned LIMIT_REGS = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DUR_W      = 32;
  localparam int unsigned CNT_W      = 64;
  localparam int unsigned IDX_W      = 4;

  // reset values of the bin limits
  localparam logic [DUR_W-1:0] LIMIT_RESET [LIMIT_REGS] = '{
    32'd50000, 32'd100000, 32'd250000, 32'd500000,
    32'd1000000, 32'd2000000, 32'd5000000
  };

  // fixed positions in the snapshot sequence
  localparam logic [IDX_W-1:0] IDX_SAMPLE = 4'd0;
  localparam logic [IDX_W-1:0] IDX_TOTAL  = 4'd1;
  localparam logic [IDX_W-1:0] IDX_PEAK   = 4'd2;
  localparam logic [IDX_W-1:0] IDX_BIN0   = 4'd3;

  // input commands
  typedef enum logic [2:0] {
    CMD_RECORD   = 3'd0,
    CMD_TIMEOUT  = 3'd1,
    CMD_USER     = 3'd2,
    CMD_OVERFLOW = 3'd3,
    CMD_SNAPSHOT = 3'd4
  } cmd_e;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  typedef struct packed {
    logic [2:0]       command;
    logic [DUR_W-1:0] duration;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] counter_index;
    logic [CNT_W-1:0] counter_value;
    logic             last;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic             count_en;
    logic             load_en;
    logic [IDX_W-1:0] load_idx;
    logic             load_last;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
  } dp_status_t;

endpackage

// ===== rtl/lhc_ctrl.sv =====
// controller: accepts input beats and sequences the snapshot readout
module lhc_ctrl import lhc_pkg::*; #(
  parameter int unsigned BIN_COUNT = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [2:0] command_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam int unsigned     NUM_RESULTS = 6 + BIN_COUNT;
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(NUM_RESULTS - 1);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             accept;
  logic             is_snap;

  // state and readout index registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // input is held off for the whole readout
  assign in_stall_o = (state_q == ST_DUMP);

  assign is_snap = (cmd_e'(command_i) == CMD_SNAPSHOT);
  assign accept  = in_valid_i && !in_stall_o;

  // next state and commands
  always_comb begin
    state_d         = state_q;
    idx_d           = idx_q;
    cmd_o.count_en  = 1'b0;
    cmd_o.load_en   = 1'b0;
    cmd_o.load_idx  = idx_q;
    cmd_o.load_last = (idx_q == LAST_IDX);
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.count_en = accept && !is_snap;
        if (accept && is_snap) begin
          state_d = ST_DUMP;
          idx_d   = '0;
        end
      end
      ST_DUMP: begin
        cmd_o.load_en = status_i.slot_free;
        if (status_i.slot_free) begin
          if (idx_q == LAST_IDX) begin
            state_d = ST_IDLE;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/lhc_dp.sv =====
// datapath: limit registers, counters, bin select and output register
module lhc_dp import lhc_pkg::*; #(
  parameter int unsigned BIN_COUNT = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  in_beat_t              in_beat_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output out_beat_t             out_beat_o
);

  localparam int unsigned      BIN_W   = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam logic [IDX_W-1:0] TMO_IDX = IDX_W'(3 + BIN_COUNT);
  localparam logic [IDX_W-1:0] USR_IDX = IDX_W'(4 + BIN_COUNT);
  localparam logic [IDX_W-1:0] OVF_IDX = IDX_W'(5 + BIN_COUNT);

  logic [DUR_W-1:0] limit_q [LIMIT_REGS];
  logic [CNT_W-1:0] sample_q, total_q, timeout_q, user_q, ovf_q;
  logic [DUR_W-1:0] peak_q;
  logic [CNT_W-1:0] bin_q [BIN_COUNT];
  logic [BIN_W-1:0] bin_sel;
  logic [IDX_W-1:0] rel_idx;
  logic [CNT_W-1:0] snap_val;
  logic             out_valid_q;
  out_beat_t        out_q;

  // bin limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LIMIT_REGS; i++) begin
        limit_q[i] <= LIMIT_RESET[i];
      end
    end else if (cfg_we_i && (cfg_index_i < CFG_IDX_W'(LIMIT_REGS))) begin
      limit_q[cfg_index_i] <= cfg_wdata_i;
    end
  end

  // first bin whose limit covers the duration, last bin otherwise
  always_comb begin
    bin_sel = BIN_W'(BIN_COUNT - 1);
    for (int i = BIN_COUNT - 2; i >= 0; i--) begin
      if (in_beat_i.duration <= limit_q[i]) begin
        bin_sel = BIN_W'(i);
      end
    end
  end

  // statistics counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q  <= '0;
      total_q   <= '0;
      peak_q    <= '0;
      timeout_q <= '0;
      user_q    <= '0;
      ovf_q     <= '0;
      for (int i = 0; i < BIN_COUNT; i++) begin
        bin_q[i] <= '0;
      end
    end else if (cmd_i.count_en) begin
      unique case (cmd_e'(in_beat_i.command))
        CMD_RECORD: begin
          sample_q       <= sample_q + 1'b1;
          total_q        <= total_q + {{(CNT_W-DUR_W){1'b0}}, in_beat_i.duration};
          bin_q[bin_sel] <= bin_q[bin_sel] + 1'b1;
          if (in_beat_i.duration > peak_q) begin
            peak_q <= in_beat_i.duration;
          end
        end
        CMD_TIMEOUT:  timeout_q <= timeout_q + 1'b1;
        CMD_USER:     user_q    <= user_q + 1'b1;
        CMD_OVERFLOW: ovf_q     <= ovf_q + 1'b1;
        default: ;
      endcase
    end
  end

  // snapshot counter select
  assign rel_idx = cmd_i.load_idx - IDX_BIN0;

  always_comb begin
    priority if (cmd_i.load_idx == IDX_SAMPLE) begin
      snap_val = sample_q;
    end else if (cmd_i.load_idx == IDX_TOTAL) begin
      snap_val = total_q;
    end else if (cmd_i.load_idx == IDX_PEAK) begin
      snap_val = {{(CNT_W-DUR_W){1'b0}}, peak_q};
    end else if (cmd_i.load_idx < TMO_IDX) begin
      snap_val = bin_q[rel_idx[BIN_W-1:0]];
    end else if (cmd_i.load_idx == TMO_IDX) begin
      snap_val = timeout_q;
    end else if (cmd_i.load_idx == USR_IDX) begin
      snap_val = user_q;
    end else if (cmd_i.load_idx == OVF_IDX) begin
      snap_val = ovf_q;
    end else begin
      snap_val = '0;
    end
  end

  // output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_en) begin
      out_q.counter_index <= cmd_i.load_idx;
      out_q.counter_value <= snap_val;
      out_q.last          <= cmd_i.load_last;
    end
  end

  assign status_o.slot_free = !out_valid_q || !out_stall_i;
  assign out_valid_o        = out_valid_q;
  assign out_beat_o         = out_q;

endmodule

// ===== rtl/latency_histogram_counters_top.sv =====
// Record and event beats are accepted one per cycle; the input is never stalled while idle.
// A snapshot beat yields 6+BIN_COUNT output beats: the controller enters the dump state,
// loads the first counter into the output register and then one per cycle from the
// readout counter unless the output stalls. The input is stalled for the whole readout.
// Reset clears all counters, loads the default bin limits and leaves the output empty.
module latency_histogram_counters_top import lhc_pkg::*; #(
  parameter int unsigned BIN_COUNT = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_beat_t              in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_beat_t             out_beat_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(5 + BIN_COUNT);

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  // sequencing
  lhc_ctrl #(
    .BIN_COUNT (BIN_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (in_beat_i.command),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  // counters and output
  lhc_dp #(
    .BIN_COUNT (BIN_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_beat_i   (in_beat_i),
    .cmd_i       (ctrl_cmd),
    .status_o    (dp_status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat_o)
  );

  // the last marker sits only on the final counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_beat_o.last == (out_beat_o.counter_index == LAST_IDX)))
    else $error("last marker does not match final counter index");

  // an accepted snapshot blocks the input on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (cmd_e'(in_beat_i.command) == CMD_SNAPSHOT))
      |=> in_stall_o)
    else $error("input not stalled after snapshot accept");

  // no counter update during a readout
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> !ctrl_cmd.count_en)
    else $error("counter update during snapshot readout");

  // a readout load never overwrites an unaccepted output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !ctrl_cmd.load_en)
    else $error("output beat overwritten while stalled");

endmodule

// ===== sim/latency_histogram_counters_top_tb.sv =====
// self-checking testbench for the latency histogram counters block
module latency_histogram_counters_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lhc_pkg::*;

  localparam int unsigned BINS          = 8;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 40;
  localparam int unsigned PHASE_ITEMS   = 60;
  localparam int          IDLE_PCT      = 32;

  localparam logic [IDX_W-1:0] IDX_TIMEOUT  = IDX_W'(IDX_BIN0 + BINS);
  localparam logic [IDX_W-1:0] IDX_USER     = IDX_W'(IDX_BIN0 + BINS + 1);
  localparam logic [IDX_W-1:0] IDX_OVERFLOW = IDX_W'(IDX_BIN0 + BINS + 2);

  // out-of-order limits with both extremes
  localparam logic [DUR_W-1:0] SHUFFLED_LIMITS [LIMIT_REGS] = '{
    32'd400000, 32'd0, 32'd90000, 32'd2000, 32'd3000000, 32'd700000, 32'hFFFF_FFFF
  };

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_beat_t              in_beat_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_beat_t             out_beat_o;

  // stimulus and expected counter dump
  in_beat_t    pending_q [$];
  out_beat_t   counter_dump_q [$];
  int          idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          beat_taken = 1'b0;
  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  // predicted block state
  logic [DUR_W-1:0] limit_q [LIMIT_REGS];
  logic [CNT_W-1:0] samples;
  logic [CNT_W-1:0] dur_sum;
  logic [DUR_W-1:0] dur_max;
  logic [CNT_W-1:0] bin_hits [BINS];
  logic [CNT_W-1:0] timeouts;
  logic [CNT_W-1:0] user_offs;
  logic [CNT_W-1:0] overflows;

  latency_histogram_counters_top #(
    .BIN_COUNT(BINS)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .in_beat_i,
    .out_valid_o,
    .out_stall_i,
    .out_beat_o
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit roll_idle();
    return $urandom_range(0, 99) < idle_pct;
  endfunction

  // first bin whose limit covers the duration, the top bin otherwise
  function automatic int unsigned pick_slot(logic [DUR_W-1:0] d);
    for (int unsigned i = 0; i + 1 < BINS && i < LIMIT_REGS; i++) begin
      if (d <= limit_q[i]) return i;
    end
    return BINS - 1;
  endfunction

  function automatic void queue_counter(logic [IDX_W-1:0] idx, logic [CNT_W-1:0] val,
                                        logic last);
    out_beat_t e;
    e.counter_index = idx;
    e.counter_value = val;
    e.last          = last;
    counter_dump_q.push_back(e);
  endfunction

  // update predicted counters for one accepted beat
  function automatic void tally_beat(in_beat_t b);
    case (b.command)
      CMD_RECORD: begin
        samples += 1;
        dur_sum += CNT_W'(b.duration);
        bin_hits[pick_slot(b.duration)] += 1;
        if (b.duration > dur_max) dur_max = b.duration;
      end
      CMD_TIMEOUT:  timeouts += 1;
      CMD_USER:     user_offs += 1;
      CMD_OVERFLOW: overflows += 1;
      CMD_SNAPSHOT: begin
        queue_counter(IDX_SAMPLE, samples, 1'b0);
        queue_counter(IDX_TOTAL, dur_sum, 1'b0);
        queue_counter(IDX_PEAK, CNT_W'(dur_max), 1'b0);
        for (int unsigned i = 0; i < BINS; i++) begin
          queue_counter(IDX_W'(IDX_BIN0 + i), bin_hits[i], 1'b0);
        end
        queue_counter(IDX_TIMEOUT, timeouts, 1'b0);
        queue_counter(IDX_USER, user_offs, 1'b0);
        queue_counter(IDX_OVERFLOW, overflows, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // durations clustered around the current limits plus the extremes
  function automatic logic [DUR_W-1:0] random_duration();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return $urandom();
    if (r < 7) return limit_q[$urandom_range(0, LIMIT_REGS - 1)] + DUR_W'($urandom_range(0, 2))
                      - 32'd1;
    if (r == 7) return '0;
    if (r == 8) return '1;
    return $urandom_range(0, 300000);
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t b;
    int unsigned r;
    b.duration = $urandom();
    r = $urandom_range(0, 99);
    if (r < 50) begin
      b.command  = CMD_RECORD;
      b.duration = random_duration();
    end else if (r < 58) begin
      b.command = CMD_TIMEOUT;
    end else if (r < 66) begin
      b.command = CMD_USER;
    end else if (r < 74) begin
      b.command = CMD_OVERFLOW;
    end else if (r < 90) begin
      b.command = CMD_SNAPSHOT;
    end else begin
      b.command = 3'(CMD_SNAPSHOT + $urandom_range(1, 3));
    end
    return b;
  endfunction

  function automatic void push_beat(logic [2:0] cmd, logic [DUR_W-1:0] dur);
    in_beat_t b;
    b.command  = cmd;
    b.duration = dur;
    pending_q.push_back(b);
  endfunction

  // ignored commands do not count toward the phase size
  task automatic load_random(int unsigned n);
    in_beat_t    b;
    int unsigned made;
    made = 0;
    while (made < n) begin
      b = random_beat();
      pending_q.push_back(b);
      if (b.command <= CMD_SNAPSHOT) made++;
    end
  endtask

  // wait until every beat is taken and every counter has come back
  task automatic drain();
    while (pending_q.size() != 0 || counter_dump_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_limit(int unsigned idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = CFG_IDX_W'(idx);
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    if (idx < LIMIT_REGS) limit_q[idx] = val;
  endtask

  // input driver, payload held until taken
  always @(negedge clk_i) begin
    if (!in_valid_i || beat_taken) begin
      beat_taken = 1'b0;
      if (pending_q.size() != 0 && !roll_idle()) begin
        in_valid_i <= 1'b1;
        in_beat_i  <= pending_q[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // input acceptance feeds the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      tally_beat(in_beat_i);
      void'(pending_q.pop_front());
      beat_taken = 1'b1;
    end
  end

  // output stall, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= roll_idle();
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    out_beat_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (counter_dump_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected beat index %0d value %0h last %0b", $realtime,
                 out_beat_o.counter_index, out_beat_o.counter_value, out_beat_o.last);
      end else begin
        e = counter_dump_q.pop_front();
        if (out_beat_o.counter_index !== e.counter_index) begin
          mismatch_count++;
          $display("%0t: counter_index expected %0d actual %0d", $realtime,
                   e.counter_index, out_beat_o.counter_index);
        end
        if (out_beat_o.counter_value !== e.counter_value) begin
          mismatch_count++;
          $display("%0t: counter_value (index %0d) expected %0h actual %0h", $realtime,
                   e.counter_index, e.counter_value, out_beat_o.counter_value);
        end
        if (out_beat_o.last !== e.last) begin
          mismatch_count++;
          $display("%0t: last (index %0d) expected %0b actual %0b", $realtime,
                   e.counter_index, e.last, out_beat_o.last);
        end
      end
    end
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("latency_histogram_counters_top_tb failed");
      $finish;
    end
  end

  initial begin
    for (int unsigned i = 0; i < LIMIT_REGS; i++) limit_q[i] = LIMIT_RESET[i];
    for (int unsigned i = 0; i < BINS; i++) bin_hits[i] = '0;
    samples   = '0;
    dur_sum   = '0;
    dur_max   = '0;
    timeouts  = '0;
    user_offs = '0;
    overflows = '0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni   = 1'b1;
    idle_pct = IDLE_PCT;

    // directed: empty snapshot, duration extremes, limit edges, every command
    push_beat(CMD_SNAPSHOT, $urandom());
    push_beat(CMD_RECORD, '0);
    push_beat(CMD_RECORD, '1);
    push_beat(CMD_RECORD, LIMIT_RESET[0]);
    push_beat(CMD_RECORD, LIMIT_RESET[0] + 32'd1);
    push_beat(CMD_RECORD, LIMIT_RESET[1]);
    push_beat(CMD_RECORD, LIMIT_RESET[LIMIT_REGS - 1]);
    push_beat(CMD_RECORD, LIMIT_RESET[LIMIT_REGS - 1] + 32'd1);
    push_beat(CMD_TIMEOUT, $urandom());
    push_beat(CMD_USER, $urandom());
    push_beat(CMD_OVERFLOW, $urandom());
    for (int unsigned k = 1; k <= 3; k++) push_beat(3'(CMD_SNAPSHOT + k), $urandom());
    push_beat(CMD_SNAPSHOT, $urandom());
    push_beat(CMD_RECORD, 32'd1);
    push_beat(CMD_SNAPSHOT, '0);
    push_beat(CMD_SNAPSHOT, '1);
    drain();

    // default limits
    load_random(PHASE_ITEMS);
    drain();

    // unsorted limits, ignored index, long output hold-off
    for (int unsigned i = 0; i < LIMIT_REGS; i++) write_limit(i, SHUFFLED_LIMITS[i]);
    write_limit(LIMIT_REGS, $urandom());
    hold_asked++;
    load_random(PHASE_ITEMS);
    drain();

    // all limits at zero, no idling on either side
    for (int unsigned i = 0; i < LIMIT_REGS; i++) write_limit(i, '0);
    idle_pct = 0;
    load_random(PHASE_ITEMS);
    drain();
    idle_pct = IDLE_PCT;

    // all limits at maximum
    for (int unsigned i = 0; i < LIMIT_REGS; i++) write_limit(i, '1);
    load_random(PHASE_ITEMS);
    drain();

    // random limits
    for (int unsigned i = 0; i < LIMIT_REGS; i++) begin
      write_limit(i, ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 6000000));
    end
    load_random(PHASE_ITEMS);
    drain();

    idle_pct = 0;
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("latency_histogram_counters_top_tb passed");
    end else begin
      $display("latency_histogram_counters_top_tb failed");
    end
    $finish;
  end

endmodule
